### rtl/core/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types, sizes and helpers for the FIFO page replacement unit.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // Storage sizes
    localparam int FRAMES    = 64;
    localparam int PAGE_BITS = 20;
    localparam int FC_W      = 7;
    localparam int FAULT_W   = 32;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CMP_W     = (FC_W > CNT_W) ? FC_W : CNT_W;

    // Operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Reset value of the frame count register
    localparam logic [FC_W-1:0] FRAME_COUNT_RST = FC_W'(3);

    // Request and response transactions
    typedef struct packed {
        logic                 operation;
        logic [PAGE_BITS-1:0] page;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [FAULT_W-1:0] fault_count;
    } rsp_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    // Result handoff from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        rsp_t data;
    } seq_result_t;

    // Frames actually searched: zero counts as one, large values clamp
    function automatic logic [CNT_W-1:0] frames_in_use(input logic [FC_W-1:0] fc);
        logic [CMP_W-1:0] fc_w;
        logic [CNT_W-1:0] used;
        fc_w = CMP_W'(fc);
        if (fc_w == '0)
            used = CNT_W'(1);
        else if (fc_w > CMP_W'(FRAMES))
            used = CNT_W'(FRAMES);
        else
            used = fc_w[CNT_W-1:0];
        return used;
    endfunction

endpackage

### rtl/core/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/fpr_seq.sv
// ----------------------------------------------------------------------------
// fpr_seq
// Search sequencer: walks the frames one per cycle through a single
// comparator, then handles hit or miss insert; a clear skips the walk.
// ----------------------------------------------------------------------------
module fpr_seq
    import fpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FC_W-1:0]   frame_count,
    input  logic              req_take,
    input  req_t              req,
    output logic              idle,
    output seq_result_t       result,
    input  logic              result_take
);

    seq_state_t state_reg, state_next;

    logic [PAGE_BITS-1:0] page_reg,       page_next;
    logic [CNT_W-1:0]     issue_idx_reg,  issue_idx_next;
    logic                 cmp_valid_reg,  cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg,    cmp_idx_next;
    logic [FRAMES-1:0]    frame_valid_reg, frame_valid_next;
    logic [CNT_W-1:0]     ptr_reg,        ptr_next;
    logic [FAULT_W-1:0]   faults_reg,     faults_next;
    logic                 hit_reg,        hit_next;

    logic [CNT_W-1:0]     used;
    logic                 issue_en;
    logic [PAGE_BITS-1:0] rd_data;
    logic                 match;
    logic                 last_cmp;
    logic [IDX_W-1:0]     slot;
    logic                 wr_en;

    assign used     = frames_in_use(frame_count);
    assign issue_en = (state_reg == ST_SCAN) && (issue_idx_reg < used);

    // Shared comparator over the frame just read
    assign match    = cmp_valid_reg && frame_valid_reg[cmp_idx_reg] && (rd_data == page_reg);
    assign last_cmp = cmp_valid_reg && (CNT_W'(cmp_idx_reg) == (used - CNT_W'(1)));

    // Insert slot: pointer past the frames in use wraps to frame 0
    assign slot = (ptr_reg >= used) ? '0 : ptr_reg[IDX_W-1:0];

    fpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_frames (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (page_reg),
        .rd_en   (issue_en),
        .rd_addr (issue_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                    state_next = (req.operation == OP_CLEAR) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (match || last_cmp)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (result_take)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        page_next        = page_reg;
        issue_idx_next   = issue_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        frame_valid_next = frame_valid_reg;
        ptr_next         = ptr_reg;
        faults_next      = faults_reg;
        hit_next         = hit_reg;
        wr_en            = 1'b0;
        idle             = 1'b0;
        result.valid     = 1'b0;
        result.data      = '{hit: hit_reg, fault_count: faults_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (req_take)
                begin
                    page_next      = req.page;
                    issue_idx_next = '0;
                    hit_next       = 1'b0;
                    if (req.operation == OP_CLEAR)
                    begin
                        frame_valid_next = '0;
                        ptr_next         = '0;
                        faults_next      = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_en)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    hit_next       = 1'b1;
                    cmp_valid_next = 1'b0;
                end
                else if (last_cmp)
                begin
                    // Miss: store the page at the insert slot
                    wr_en                  = 1'b1;
                    frame_valid_next[slot] = 1'b1;
                    ptr_next               = CNT_W'(slot) + CNT_W'(1);
                    if (faults_reg != '1)
                        faults_next = faults_reg + FAULT_W'(1);
                    cmp_valid_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                result.valid = 1'b1;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmp_valid_reg   <= 1'b0;
            frame_valid_reg <= '0;
            ptr_reg         <= '0;
            faults_reg      <= '0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmp_valid_reg   <= cmp_valid_next;
            frame_valid_reg <= frame_valid_next;
            ptr_reg         <= ptr_next;
            faults_reg      <= faults_next;
            hit_reg         <= hit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
    end

endmodule

### rtl/core/fifo_page_replacement_unit.sv
// An access searches up to the frames in use (64 max), stopping at a hit; a clear skips
// the search. One transaction at a time; while the output does not stall, throughput is
// set by the one-frame-per-cycle search through the frame RAM.
// Reset empties all frames, zeroes the fault count and insert pointer, and sets the
// frame count to 3; no clearing pass is needed (per-frame valid flops).
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit
// FIFO page replacement simulator with a configurable number of frames.
// ----------------------------------------------------------------------------
module fifo_page_replacement_unit
    import fpr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [FC_W-1:0] cfg_wr_data,
    input  logic            req_valid,
    output logic            req_stall,
    input  req_t            req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output rsp_t            rsp
);

    logic [FC_W-1:0] frame_count_reg;
    logic            rsp_valid_reg;
    rsp_t            rsp_reg;

    logic            idle;
    logic            req_take;
    logic            out_free;
    logic            result_take;
    seq_result_t     result;

    // Frame count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_count_reg <= FRAME_COUNT_RST;
        else if (cfg_wr_en)
            frame_count_reg <= cfg_wr_data;
    end

    // Input handshake
    assign req_stall = !idle;
    assign req_take  = req_valid && idle;

    fpr_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_count (frame_count_reg),
        .req_take    (req_take),
        .req         (req),
        .idle        (idle),
        .result      (result),
        .result_take (result_take)
    );

    // Output register
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign result_take = result.valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_free)
            rsp_valid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (result_take)
            rsp_reg <= result.data;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
